// ===== sv/sactls_pkg.sv =====
package sactls_pkg;

  localparam int unsigned WAYS_DEF       = 4;
  localparam int unsigned SETS_DEF       = 64;
  localparam int unsigned TAG_BITS_DEF   = 20;
  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned AGE_BITS_DEF   = 8;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SET_IN_W  = 6;
  localparam int unsigned TAG_IN_W  = 20;
  localparam int unsigned OFF_IN_W  = 5;
  localparam int unsigned REQ_IN_W  = 4;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned WAY_OUT_W = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned SET_LSB = 0;
  localparam int unsigned TAG_LSB = SET_LSB + SET_IN_W;
  localparam int unsigned OFF_LSB = TAG_LSB + TAG_IN_W;
  localparam int unsigned REQ_LSB = OFF_LSB + OFF_IN_W;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SNOOP = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACCESS,
    KIND_INVAL,
    KIND_VALIDATE,
    KIND_NOP
  } kind_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } q_ctl_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

endpackage

// ===== sv/sactls_ram.sv =====
module sactls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sactls_front.sv =====
module sactls_front #(
  parameter int unsigned SETS       = sactls_pkg::SETS_DEF,
  parameter int unsigned TAG_BITS   = sactls_pkg::TAG_BITS_DEF,
  parameter int unsigned LINE_BYTES = sactls_pkg::LINE_BYTES_DEF,
  localparam int unsigned SIDX = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sactls_pkg::ID_W-1:0]      own_id_i,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [sactls_pkg::OP_W-1:0]      op_i,
  input  logic [sactls_pkg::IN_DATA_W-1:0] data_i,
  input  sactls_pkg::bk_stat_t             stat_i,
  output sactls_pkg::q_ctl_t               ctl_o,
  output logic [SIDX-1:0]                  set_o,
  output logic [TAG_BITS-1:0]              tag_o
);

  localparam int unsigned SET_VALS = 2 ** sactls_pkg::SET_IN_W;
  localparam int unsigned OFF_VALS = 2 ** sactls_pkg::OFF_IN_W;
  localparam int unsigned QDEPTH   = 2;

  logic [SIDX-1:0] set_lut [SET_VALS];
  logic            off_zero_lut [OFF_VALS];

  for (genvar i = 0; i < SET_VALS; i++) begin : g_set_lut
    assign set_lut[i] = SIDX'(i % SETS);
  end

  for (genvar j = 0; j < OFF_VALS; j++) begin : g_off_lut
    assign off_zero_lut[j] = ((j % LINE_BYTES) == 0);
  end

  logic [sactls_pkg::SET_IN_W-1:0] raw_set;
  logic [sactls_pkg::TAG_IN_W-1:0] raw_tag;
  logic [sactls_pkg::OFF_IN_W-1:0] raw_off;
  logic [sactls_pkg::REQ_IN_W-1:0] raw_req;
  logic [TAG_BITS-1:0]             tag_eff;
  logic                            addr_zero;
  sactls_pkg::kind_e               kind;

  always_comb begin
    raw_set   = data_i[sactls_pkg::SET_LSB +: sactls_pkg::SET_IN_W];
    raw_tag   = data_i[sactls_pkg::TAG_LSB +: sactls_pkg::TAG_IN_W];
    raw_off   = data_i[sactls_pkg::OFF_LSB +: sactls_pkg::OFF_IN_W];
    raw_req   = data_i[sactls_pkg::REQ_LSB +: sactls_pkg::REQ_IN_W];
    tag_eff   = TAG_BITS'(raw_tag);
    addr_zero = (tag_eff == '0) && (raw_set == '0) && off_zero_lut[raw_off];
    unique case (op_i)
      sactls_pkg::OP_READ, sactls_pkg::OP_WRITE: kind = sactls_pkg::KIND_ACCESS;
      sactls_pkg::OP_SNOOP: begin
        if (addr_zero) begin
          kind = sactls_pkg::KIND_NOP;
        end else if (raw_req == own_id_i) begin
          kind = sactls_pkg::KIND_VALIDATE;
        end else begin
          kind = sactls_pkg::KIND_INVAL;
        end
      end
      default: kind = sactls_pkg::KIND_NOP;
    endcase
  end

  sactls_pkg::kind_e   ent_kind_q [QDEPTH];
  logic [SIDX-1:0]     ent_set_q  [QDEPTH];
  logic [TAG_BITS-1:0] ent_tag_q  [QDEPTH];
  logic                wp_q, wp_d, rp_q, rp_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                push, pop;

  assign s_ready_o = (cnt_q != 2'(QDEPTH)) && !stat_i.clearing;
  assign push      = s_valid_i && s_ready_o;
  assign pop       = stat_i.pop && (cnt_q != '0);

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_kind_q[wp_q] <= kind;
      ent_set_q[wp_q]  <= set_lut[raw_set];
      ent_tag_q[wp_q]  <= tag_eff;
    end
  end

  assign ctl_o.valid = (cnt_q != '0);
  assign ctl_o.kind  = ent_kind_q[rp_q];
  assign set_o       = ent_set_q[rp_q];
  assign tag_o       = ent_tag_q[rp_q];

endmodule

// ===== sv/sactls_back.sv =====
module sactls_back #(
  parameter int unsigned WAYS     = sactls_pkg::WAYS_DEF,
  parameter int unsigned SETS     = sactls_pkg::SETS_DEF,
  parameter int unsigned TAG_BITS = sactls_pkg::TAG_BITS_DEF,
  parameter int unsigned AGE_BITS = sactls_pkg::AGE_BITS_DEF,
  localparam int unsigned SIDX = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sactls_pkg::q_ctl_t                ctl_i,
  input  logic [SIDX-1:0]                   set_i,
  input  logic [TAG_BITS-1:0]               tag_i,
  output sactls_pkg::bk_stat_t              stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_hit_o,
  output logic [sactls_pkg::WAY_OUT_W-1:0]  out_way_o
);

  localparam int unsigned WB = $clog2(WAYS);
  localparam int unsigned E  = TAG_BITS + 1 + AGE_BITS;
  localparam int unsigned RW = WAYS * E;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  sactls_pkg::bk_state_e state_q, state_d;
  logic [SIDX-1:0]       clr_cnt_q, clr_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q;
  logic [sactls_pkg::WAY_OUT_W-1:0] out_way_q;
  sactls_pkg::kind_e     it_kind_q;
  logic [SIDX-1:0]       it_set_q;
  logic [TAG_BITS-1:0]   it_tag_q;

  logic            out_free, clr_last;
  logic            ram_re, ram_we, out_load, pop;
  logic [SIDX-1:0] ram_waddr;
  logic [RW-1:0]   ram_wdata, rd_row, new_row;

  logic [TAG_BITS-1:0] w_tag [WAYS];
  logic                w_val [WAYS];
  logic [AGE_BITS-1:0] w_age [WAYS];
  logic [TAG_BITS-1:0] n_tag [WAYS];
  logic                n_val [WAYS];
  logic [AGE_BITS-1:0] n_age [WAYS];
  logic                acc_hit, found_empty, snp_hit, res_hit;
  logic [WB-1:0]       hit_way, empty_way, old_way, sel;
  logic [AGE_BITS-1:0] best_age;
  logic [sactls_pkg::WAY_OUT_W-1:0] res_way;

  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (clr_cnt_q == SIDX'(SETS - 1));

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      sactls_pkg::BK_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_last) begin
          state_d = sactls_pkg::BK_FETCH;
        end
      end
      sactls_pkg::BK_FETCH: begin
        if (ctl_i.valid) begin
          state_d = sactls_pkg::BK_EXEC;
        end
      end
      sactls_pkg::BK_EXEC: begin
        if (out_free) begin
          state_d = sactls_pkg::BK_FETCH;
        end
      end
      default: state_d = sactls_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ram_waddr = it_set_q;
    ram_wdata = new_row;
    stat_o.clearing = 1'b0;
    unique case (state_q)
      sactls_pkg::BK_CLEAR: begin
        stat_o.clearing = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      sactls_pkg::BK_FETCH: begin
        pop    = ctl_i.valid;
        ram_re = ctl_i.valid;
      end
      sactls_pkg::BK_EXEC: begin
        out_load = out_free;
        ram_we   = out_free && (it_kind_q != sactls_pkg::KIND_NOP);
      end
      default: begin
        stat_o.clearing = 1'b1;
      end
    endcase
    stat_o.pop = pop;
  end

  sactls_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_i),
    .rdata_o (rd_row)
  );

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      w_tag[w] = rd_row[w*E +: TAG_BITS];
      w_val[w] = rd_row[w*E + TAG_BITS];
      w_age[w] = rd_row[w*E + TAG_BITS + 1 +: AGE_BITS];
    end

    acc_hit     = 1'b0;
    hit_way     = '0;
    found_empty = 1'b0;
    empty_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w_val[w] && (w_tag[w] == it_tag_q)) begin
        acc_hit = 1'b1;
        hit_way = WB'(w);
      end
      if (w_age[w] == '0) begin
        found_empty = 1'b1;
        empty_way   = WB'(w);
      end
    end
    best_age = '0;
    old_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w_age[w] > best_age) begin
        best_age = w_age[w];
        old_way  = WB'(w);
      end
    end
    if (acc_hit) begin
      sel = hit_way;
    end else if (found_empty) begin
      sel = empty_way;
    end else begin
      sel = old_way;
    end

    snp_hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      n_tag[w] = w_tag[w];
      n_val[w] = w_val[w];
      n_age[w] = w_age[w];
      unique case (it_kind_q)
        sactls_pkg::KIND_ACCESS: begin
          if (WB'(w) == sel) begin
            n_age[w] = AGE_BITS'(1);
            if (!acc_hit) begin
              n_tag[w] = it_tag_q;
              n_val[w] = 1'b1;
            end
          end else if ((w_age[w] != '0) && (w_age[w] != AGE_MAX)) begin
            n_age[w] = w_age[w] + 1'b1;
          end
        end
        sactls_pkg::KIND_INVAL, sactls_pkg::KIND_VALIDATE: begin
          if (w_tag[w] == it_tag_q) begin
            snp_hit  = 1'b1;
            n_val[w] = (it_kind_q == sactls_pkg::KIND_VALIDATE);
          end
        end
        default: begin
        end
      endcase
      new_row[w*E +: E] = {n_age[w], n_val[w], n_tag[w]};
    end

    unique case (it_kind_q)
      sactls_pkg::KIND_ACCESS: begin
        res_hit = acc_hit;
        res_way = sactls_pkg::WAY_OUT_W'(sel);
      end
      sactls_pkg::KIND_INVAL, sactls_pkg::KIND_VALIDATE: begin
        res_hit = snp_hit;
        res_way = '0;
      end
      default: begin
        res_hit = 1'b0;
        res_way = '0;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sactls_pkg::BK_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      it_kind_q <= ctl_i.kind;
      it_set_q  <= set_i;
      it_tag_q  <= tag_i;
    end
    if (out_load) begin
      out_hit_q <= res_hit;
      out_way_q <= res_way;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_way_o   = out_way_q;

endmodule

// ===== sv/set_assoc_cache_tags_lru_snoop.sv =====
// Tag, valid and age store of a set-associative write-through cache.
// Requests enter on the s_axis channel: tuser carries the operation (read,
// write or snooped bus write) and tdata the set index, tag, byte offset and
// requester. Each request gives exactly one item on the m_axis channel with
// the hit flag and the way that was hit or filled (zero for snoops and no-ops), in request order.
// The front end classifies requests into a two-entry queue. The back end
// reads the whole set from a single-port-per-direction RAM in its fetch
// state and writes the updated set back in its exec state once the output
// register is free; it finishes one request before fetching the next, and
// the RAM read and the write-back of each set bound its rate. A request
// passes through the queue, the fetch state and the exec state to the output register.
// After reset the set RAM is cleared, one set per cycle; s_axis_tready
// stays low during that pass while own_id writes are still taken. When
// the receiver stalls, the finished item waits in the output register and
// the queue keeps taking requests until it is full.
module set_assoc_cache_tags_lru_snoop #(
  parameter int unsigned WAYS       = sactls_pkg::WAYS_DEF,
  parameter int unsigned SETS       = sactls_pkg::SETS_DEF,
  parameter int unsigned TAG_BITS   = sactls_pkg::TAG_BITS_DEF,
  parameter int unsigned LINE_BYTES = sactls_pkg::LINE_BYTES_DEF,
  parameter int unsigned AGE_BITS   = sactls_pkg::AGE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sactls_pkg::ID_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // set_index[5:0], tag[25:6], line_offset[30:26], requester_id[34:31].
  input  logic [sactls_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0].
  input  logic [sactls_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit[0], way[2:1].
  output logic [sactls_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned SIDX = (SETS > 1) ? $clog2(SETS) : 1;

  logic [sactls_pkg::ID_W-1:0] own_id_q, own_id_d;
  sactls_pkg::q_ctl_t          q_ctl;
  sactls_pkg::bk_stat_t        bk_stat;
  logic [SIDX-1:0]             q_set;
  logic [TAG_BITS-1:0]         q_tag;
  logic                        out_hit;
  logic [sactls_pkg::WAY_OUT_W-1:0] out_way;

  assign own_id_d = cfg_we_i ? cfg_wdata_i : own_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else begin
      own_id_q <= own_id_d;
    end
  end

  sactls_front #(
    .SETS       (SETS),
    .TAG_BITS   (TAG_BITS),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .own_id_i  (own_id_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (s_axis_tuser),
    .data_i    (s_axis_tdata),
    .stat_i    (bk_stat),
    .ctl_o     (q_ctl),
    .set_o     (q_set),
    .tag_o     (q_tag)
  );

  sactls_back #(
    .WAYS     (WAYS),
    .SETS     (SETS),
    .TAG_BITS (TAG_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (q_ctl),
    .set_i       (q_set),
    .tag_i       (q_tag),
    .stat_o      (bk_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_way_o   (out_way)
  );

  assign m_axis_tdata = {
    (sactls_pkg::OUT_DATA_W - 1 - sactls_pkg::WAY_OUT_W)'(0), out_way, out_hit
  };

endmodule
